>>> design/olst_pkg.sv
// Shared types and codes for the ordered list store.
`timescale 1ns / 1ps

package olst_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DEL_POS = 3'd1,
    OP_DEL_VAL = 3'd2,
    OP_MODIFY  = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RUN,
    S_DONE
  } state_t;

endpackage

>>> design/ordered_list_store_core.sv
// Top level of the ordered list store: sequencer plus element RAM.
`timescale 1ns / 1ps
//
//  channel  valid      stall      payload
//  in       in_valid   in_stall   opcode, position, value
//  out      out_valid  out_stall  status, read_value, length
//
//  Modify, failed checks and the no-shift cases go straight to the result; read
//  passes through a RAM read state first. Insert and delete-at-position move elements,
//  delete-by-value scans the whole list: one RAM read and at most one write per cycle.
//  Reset empties the list at once; RAM contents are left as they are.
//  in_stall is low only while idle. A finished result waits in the output
//  register while the next item is taken; that item's result holds until it frees.

module ordered_list_store_core #(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [8:0]         length
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  olst_engine #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_value (read_value),
    .length     (length),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  olst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> design/olst_ram.sv
// Element storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module olst_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/olst_engine.sv
// Operation sequencer: decode, shift/compact loop over the RAM, result register.
`timescale 1ns / 1ps

module olst_engine
  import olst_pkg::*;
#(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               opcode,
  input  logic [7:0]               position,
  input  logic signed [31:0]       value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [31:0]       read_value,
  output logic [8:0]               length,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [ELEMENT_WIDTH-1:0] mem_rdata
);

  localparam int PW = (CW > 8) ? CW : 8;

  state_t state, state_next;

  logic [CW-1:0]            count;
  logic [2:0]               op_r;
  logic [AW-1:0]            pos_r;
  logic [ELEMENT_WIDTH-1:0] val_r;
  logic [AW-1:0]            src;
  logic [AW-1:0]            stop;
  logic                     more;
  logic                     rv;
  logic [AW-1:0]            rsrc;
  logic [CW-1:0]            wptr;
  status_t                  res_status;
  logic [31:0]              res_rd;

  // input value trimmed or zero-extended to element width
  logic [ELEMENT_WIDTH+31:0] vext;
  logic [ELEMENT_WIDTH-1:0]  elem_in;
  logic [ELEMENT_WIDTH+31:0] rext;
  logic [CW+8:0]             cext;

  assign vext    = {{ELEMENT_WIDTH{1'b0}}, value};
  assign elem_in = vext[ELEMENT_WIDTH-1:0];
  assign rext    = {32'd0, mem_rdata};
  assign cext    = {9'd0, count};

  // accept-time decode
  logic [PW-1:0] pos_w, cnt_w;
  logic          pos_lt, pos_le, pos_last, pos_end;
  status_t       acc_status;
  logic          acc_shift, acc_read, acc_write, acc_inc, acc_dec;
  logic [AW-1:0] acc_src, acc_stop;
  logic          accept, out_load, finish, keep;

  assign pos_w    = PW'(position);
  assign cnt_w    = PW'(count);
  assign pos_lt   = pos_w < cnt_w;
  assign pos_le   = pos_w <= cnt_w;
  assign pos_end  = pos_w == cnt_w;
  assign pos_last = (pos_w + PW'(1)) == cnt_w;
  assign accept   = (state == S_IDLE) && in_valid;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);
  assign finish   = (state == S_RUN) && !more && !rv;
  assign keep     = mem_rdata != val_r;

  always_comb begin
    acc_status = ST_OK;
    acc_shift  = 1'b0;
    acc_read   = 1'b0;
    acc_write  = 1'b0;
    acc_inc    = 1'b0;
    acc_dec    = 1'b0;
    acc_src    = AW'(position);
    acc_stop   = AW'(position);
    case (opcode)
      OP_INSERT: begin
        if (!pos_le) begin
          acc_status = ST_BAD_POS;
        end else if (count == CW'(CAPACITY)) begin
          acc_status = ST_FULL;
        end else if (pos_end) begin
          acc_write = 1'b1;
          acc_inc   = 1'b1;
        end else begin
          acc_shift = 1'b1;
          acc_src   = AW'(count - CW'(1));
        end
      end
      OP_DEL_POS: begin
        if (!pos_lt) begin
          acc_status = ST_BAD_POS;
        end else if (pos_last) begin
          acc_dec = 1'b1;
        end else begin
          acc_shift = 1'b1;
          acc_src   = AW'(position) + AW'(1);
          acc_stop  = AW'(count - CW'(1));
        end
      end
      OP_DEL_VAL: begin
        if (count != '0) begin
          acc_shift = 1'b1;
          acc_src   = '0;
          acc_stop  = AW'(count - CW'(1));
        end
      end
      OP_MODIFY: begin
        if (!pos_lt) begin
          acc_status = ST_BAD_POS;
        end else begin
          acc_write = 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_lt) begin
          acc_status = ST_BAD_POS;
        end else begin
          acc_read = 1'b1;
        end
      end
      default: begin
        acc_status = ST_BAD_POS;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (acc_shift) begin
            state_next = S_RUN;
          end else if (acc_read) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: state_next = S_DONE;
      S_RUN: begin
        if (finish) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and RAM port control
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = AW'(position);
    mem_wdata = elem_in;
    mem_re    = 1'b0;
    mem_raddr = AW'(position);
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        mem_we   = in_valid && acc_write;
        mem_re   = in_valid && acc_read;
      end
      S_RUN: begin
        mem_re    = more;
        mem_raddr = src;
        if (rv) begin
          mem_wdata = mem_rdata;
          case (op_r)
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = rsrc + AW'(1);
            end
            OP_DEL_POS: begin
              mem_we    = 1'b1;
              mem_waddr = rsrc - AW'(1);
            end
            OP_DEL_VAL: begin
              mem_we    = keep;
              mem_waddr = AW'(wptr);
            end
            default: mem_we = 1'b0;
          endcase
        end else if (!more && (op_r == OP_INSERT)) begin
          // shift done: drop the new element into the gap
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = val_r;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      more      <= 1'b0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= (state == S_RUN) && more;
      if (accept) begin
        more <= acc_shift;
        if (acc_inc) begin
          count <= count + CW'(1);
        end else if (acc_dec) begin
          count <= count - CW'(1);
        end
      end else if ((state == S_RUN) && more && (src == stop)) begin
        more <= 1'b0;
      end
      if (finish) begin
        case (op_r)
          OP_INSERT:  count <= count + CW'(1);
          OP_DEL_POS: count <= count - CW'(1);
          default:    count <= wptr;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= opcode;
      pos_r      <= AW'(position);
      val_r      <= elem_in;
      src        <= acc_src;
      stop       <= acc_stop;
      wptr       <= '0;
      res_status <= acc_status;
      res_rd     <= '0;
    end
    if ((state == S_RUN) && more) begin
      src <= (op_r == OP_INSERT) ? src - AW'(1) : src + AW'(1);
    end
    rsrc <= src;
    if ((state == S_RUN) && rv && (op_r == OP_DEL_VAL) && keep) begin
      wptr <= wptr + CW'(1);
    end
    if (state == S_READ) begin
      res_rd <= rext[31:0];
    end
    if (out_load) begin
      status     <= res_status;
      read_value <= res_rd;
      length     <= cext[8:0];
    end
  end

endmodule

>>> dv/tb.sv
// Self-checking testbench for the ordered list store: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
  import olst_pkg::*;

  localparam int CAPACITY = 256;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;
  } list_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [8:0]  length;
  } list_result_t;

  typedef struct packed {
    list_item_t   item;
    bit           typed;
    list_result_t result;
  } directed_row_t;

  localparam list_result_t NO_CHECK = '{ST_OK, 32'd0, 9'd0};

  // Rows with typed = 1 carry a hand-written expectation; the rest use the predictor.
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    '{'{OP_READ,      8'd0,   32'd0},         1'b1, '{ST_BAD_POS, 32'd0,         9'd0}},
    '{'{OP_INSERT,    8'd1,   32'd0},         1'b1, '{ST_BAD_POS, 32'd0,         9'd0}},
    '{'{OP_DEL_POS,   8'd0,   32'd0},         1'b1, '{ST_BAD_POS, 32'd0,         9'd0}},
    '{'{OP_UNUSED_HI, 8'd0,   32'd0},         1'b1, '{ST_BAD_POS, 32'd0,         9'd0}},
    '{'{OP_DEL_VAL,   8'd0,   32'd0},         1'b1, '{ST_OK,      32'd0,         9'd0}},
    '{'{OP_INSERT,    8'd0,   32'h7fff_ffff}, 1'b1, '{ST_OK,      32'd0,         9'd1}},
    '{'{OP_INSERT,    8'd1,   32'h8000_0000}, 1'b1, '{ST_OK,      32'd0,         9'd2}},
    '{'{OP_READ,      8'd0,   32'd0},         1'b1, '{ST_OK,      32'h7fff_ffff, 9'd2}},
    '{'{OP_READ,      8'd1,   32'hffff_ffff}, 1'b1, '{ST_OK,      32'h8000_0000, 9'd2}},
    '{'{OP_READ,      8'd2,   32'd0},         1'b1, '{ST_BAD_POS, 32'd0,         9'd2}},
    '{'{OP_INSERT,    8'd0,   32'hffff_ffff}, 1'b1, '{ST_OK,      32'd0,         9'd3}},
    '{'{OP_INSERT,    8'd3,   32'd5},         1'b1, '{ST_OK,      32'd0,         9'd4}},
    '{'{OP_INSERT,    8'd5,   32'd0},         1'b1, '{ST_BAD_POS, 32'd0,         9'd4}},
    '{'{OP_MODIFY,    8'd1,   32'd5},         1'b1, '{ST_OK,      32'd0,         9'd4}},
    '{'{OP_DEL_VAL,   8'd0,   32'd5},         1'b0, NO_CHECK},
    '{'{OP_DEL_VAL,   8'd0,   32'd1234},      1'b0, NO_CHECK},
    '{'{OP_MODIFY,    8'd2,   32'd0},         1'b0, NO_CHECK},
    '{'{OP_UNUSED_LO, 8'd0,   32'd0},         1'b0, NO_CHECK},
    '{'{OP_UNUSED_MID, 8'd1,  32'd0},         1'b0, NO_CHECK},
    '{'{OP_READ,      8'd255, 32'd0},         1'b0, NO_CHECK},
    '{'{OP_INSERT,    8'd255, 32'd0},         1'b0, NO_CHECK},
    '{'{OP_DEL_POS,   8'd1,   32'd0},         1'b0, NO_CHECK},
    '{'{OP_READ,      8'd0,   32'd0},         1'b0, NO_CHECK},
    '{'{OP_DEL_POS,   8'd0,   32'd0},         1'b0, NO_CHECK},
    '{'{OP_DEL_POS,   8'd0,   32'd0},         1'b0, NO_CHECK}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         opcode = OP_INSERT;
  logic [7:0]         position = 8'd0;
  logic signed [31:0] value = 32'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [8:0]         length;

  logic [31:0]  list_elems [CAPACITY];
  int           list_len = 0;
  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_request = 1'b0;
  int           hold_cycles = 0;

  ordered_list_store_core #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_WIDTH(32)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .read_value(read_value),
    .length    (length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 200) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Applies one operation to the shadow list and returns the result it must produce.
  function automatic list_result_t apply_list_op(input list_item_t it);
    list_result_t r;
    int i;
    int j;
    r = NO_CHECK;
    case (it.op)
      OP_INSERT: begin
        if (it.pos > list_len) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > it.pos; i--) list_elems[i] = list_elems[i - 1];
          list_elems[it.pos] = it.val;
          list_len++;
        end
      end
      OP_DEL_POS: begin
        if (it.pos >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (j = it.pos; j + 1 < list_len; j++) list_elems[j] = list_elems[j + 1];
          list_len--;
        end
      end
      OP_DEL_VAL: begin
        // scan from the top so removals never skip an element
        for (i = list_len; i > 0; i--) begin
          if (list_elems[i - 1] == it.val) begin
            for (j = i - 1; j + 1 < list_len; j++) list_elems[j] = list_elems[j + 1];
            list_len--;
          end
        end
      end
      OP_MODIFY: begin
        if (it.pos >= list_len) r.status = ST_BAD_POS;
        else list_elems[it.pos] = it.val;
      end
      OP_READ: begin
        if (it.pos >= list_len) r.status = ST_BAD_POS;
        else r.read_value = list_elems[it.pos];
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.length = 9'(list_len);
    return r;
  endfunction

  // Random operation steered toward a target list length.
  function automatic list_item_t pick_list_op(input int target);
    list_item_t it;
    int roll;
    int ins_cut;
    int del_w;
    int dv_w;
    int hi;
    bit dup_heavy;
    dup_heavy = (target < 64);
    // while growing, keep delete-by-value rare so a large target is reached
    ins_cut = (list_len < target) ? 76 : 22;
    del_w = (list_len < target) ? 6 : 30;
    dv_w = (list_len < target) ? 2 : 8;
    roll = $urandom_range(99);
    if (roll < 2) begin
      it.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end else if (roll < ins_cut) begin
      it.op = OP_INSERT;
    end else if (roll - ins_cut < del_w) begin
      it.op = OP_DEL_POS;
    end else if (roll - ins_cut < del_w + dv_w) begin
      it.op = OP_DEL_VAL;
    end else begin
      it.op = $urandom_range(1) ? OP_MODIFY : OP_READ;
    end

    hi = (it.op == OP_INSERT) ? list_len : list_len - 1;
    if (hi > 255) hi = 255;
    roll = $urandom_range(99);
    if (roll < 10 || hi < 0) it.pos = 8'($urandom_range(255));
    else if (roll < 16) it.pos = 8'd0;
    else if (roll < 22) it.pos = 8'(hi);
    else it.pos = 8'($urandom_range(hi, 0));

    roll = $urandom_range(99);
    if (dup_heavy && roll < 30) begin
      it.val = $urandom_range(7);
    end else if (roll < 40) begin
      case ($urandom_range(3))
        0: it.val = 32'h0000_0000;
        1: it.val = 32'h7fff_ffff;
        2: it.val = 32'h8000_0000;
        default: it.val = 32'hffff_ffff;
      endcase
    end else if (dup_heavy && roll < 55 && list_len > 0) begin
      it.val = list_elems[$urandom_range(list_len - 1)];
    end else begin
      it.val = $urandom;
    end
    return it;
  endfunction

  task automatic push_item(input list_item_t it, input bit typed, input list_result_t typed_res);
    list_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    position <= it.pos;
    value <= it.val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = apply_list_op(it);
    pending_results.push_back(typed ? typed_res : want);
  endtask

  task automatic run_phase(input int n_items, input int target_lo, input int target_hi);
    int target;
    int n;
    target = target_lo;
    for (n = 0; n < n_items; n++) begin
      if (n % 40 == 0) target = $urandom_range(target_hi, target_lo);
      push_item(pick_list_op(target), 1'b0, NO_CHECK);
    end
  endtask

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with no transfer pending: status %0d length %0d",
                                status, length));
    end else begin
      want = pending_results.pop_front();
      if (status != want.status)
        report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
      if (read_value != want.read_value)
        report_mismatch($sformatf("read_value got %h expected %h", read_value,
                                  want.read_value));
      if (length != want.length)
        report_mismatch($sformatf("length got %0d expected %0d", length, want.length));
    end
  endtask

  // Result side: check every transfer, stall at random or for a long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int r;
    int mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 65;
    for (r = 0; r < 25; r++)
      push_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 65 : 0;
      recv_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 36 : 0;
      if (mode == 2) hold_request = 1'b1;
      repeat (3) run_phase(120, 0, 24);
    end
    // grow to full, sit at capacity, then shrink again
    run_phase(500, CAPACITY, CAPACITY);
    run_phase(100, 0, 0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/olst_pkg.sv
design/olst_ram.sv
design/olst_engine.sv
design/ordered_list_store_core.sv
dv/tb.sv
